// ===== hdl/rbsi_pkg.sv =====
package rbsi_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned HalfW  = 31;
  localparam int unsigned FracW  = 16;
  // Face minus origin needs two bits above a coordinate.
  localparam int unsigned DiffW  = CoordW + 2;
  // Scaled dividend magnitude.
  localparam int unsigned RemW   = DiffW + FracW;
  localparam int unsigned QuotW  = CoordW;
  localparam int unsigned NumAxes = 3;
  // Sign/scale stage, one stage per quotient bit, range-check stage.
  localparam int unsigned DivLat = QuotW + 2;
  // Face stage, divider, ordering stage, reduction stage.
  localparam int unsigned PipeLat = DivLat + 3;

  localparam int unsigned InDataW  = 384;
  localparam int unsigned OutDataW = 72;

  typedef struct packed {
    logic                     ok;
    logic signed [QuotW-1:0]  t;
  } quot_t;

endpackage

// ===== hdl/rbsi_div.sv =====
module rbsi_div (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [rbsi_pkg::DiffW-1:0]      num_i,
  input  logic signed [rbsi_pkg::CoordW-1:0]     den_i,
  output rbsi_pkg::quot_t                        quot_o
);

  localparam int unsigned Steps = rbsi_pkg::QuotW;
  localparam int unsigned RemW  = rbsi_pkg::RemW;
  localparam int unsigned DW    = rbsi_pkg::CoordW;

  logic [RemW-1:0]                 rem_q  [0:Steps];
  logic [rbsi_pkg::QuotW-1:0]      quo_q  [0:Steps];
  logic [DW-1:0]                   dmag_q [0:Steps];
  logic                            neg_q  [0:Steps];
  logic                            bad_q  [0:Steps];

  logic [rbsi_pkg::DiffW-1:0]      nmag;
  logic [DW-1:0]                   dmag;
  logic                            bad;
  rbsi_pkg::quot_t                 quot_d, quot_q;

  always_comb begin
    nmag = num_i[rbsi_pkg::DiffW-1] ? rbsi_pkg::DiffW'(-num_i) : rbsi_pkg::DiffW'(num_i);
    dmag = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    // The quotient reaches 2^32 exactly when the dividend holds the divisor times 2^32.
    bad  = (den_i == '0) ||
           ({{(DW+rbsi_pkg::FracW-rbsi_pkg::DiffW){1'b0}},
             nmag[rbsi_pkg::DiffW-1:rbsi_pkg::FracW]} >= dmag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {nmag, {rbsi_pkg::FracW{1'b0}}};
      quo_q[0]  <= '0;
      dmag_q[0] <= dmag;
      neg_q[0]  <= num_i[rbsi_pkg::DiffW-1] ^ den_i[DW-1];
      bad_q[0]  <= bad;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int unsigned Sh = Steps - 1 - k;
    logic [RemW-1:0] shifted;
    logic [DW:0]     top;
    logic [DW+1:0]   trial;
    logic            take;
    logic [RemW-1:0] rem_d;

    // The remainder stays below the divisor shifted one place further, so its
    // upper part fits in one bit more than the divisor.
    always_comb begin
      shifted = rem_q[k] >> Sh;
      top     = shifted[DW:0];
      trial   = {1'b0, top} - {2'b0, dmag_q[k]};
      take    = !trial[DW+1];
      rem_d   = rem_q[k];
      if (take) begin
        rem_d = rem_q[k] - (RemW'(dmag_q[k]) << Sh);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_d;
        quo_q[k+1]  <= {quo_q[k][rbsi_pkg::QuotW-2:0], take};
        dmag_q[k+1] <= dmag_q[k];
        neg_q[k+1]  <= neg_q[k];
        bad_q[k+1]  <= bad_q[k];
      end
    end
  end

  always_comb begin
    quot_d.ok = !bad_q[Steps] &&
                (!quo_q[Steps][rbsi_pkg::QuotW-1] ||
                 (neg_q[Steps] && quo_q[Steps][rbsi_pkg::QuotW-2:0] == '0));
    quot_d.t  = neg_q[Steps] ? -quo_q[Steps] : quo_q[Steps];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

// ===== hdl/ray_box_slab_intersect.sv =====
// Ray versus axis-aligned box test by the slab method, fully pipelined: one
// item is accepted every clock cycle while the output side does not stall.
// Most register stages lie in the six face dividers, which resolve one
// quotient bit per register stage. A back-pressured output freezes the
// whole pipeline, so nothing is lost or repeated. A zero direction
// component, or a face parameter outside the signed Q16.16 range, reports
// a miss with both parameters zero.
module ray_box_slab_intersect (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // center_x, center_y, center_z, half_x, half_y, half_z, origin_x, origin_y,
  // origin_z, dir_x, dir_y, dir_z; zero padding above bit 380.
  input  logic [rbsi_pkg::InDataW-1:0]        s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // hit, t_enter, t_exit; zero padding above bit 64.
  output logic [rbsi_pkg::OutDataW-1:0]       m_axis_tdata
);

  localparam int unsigned Lat = rbsi_pkg::PipeLat;
  localparam int unsigned CW  = rbsi_pkg::CoordW;
  localparam int unsigned HW  = rbsi_pkg::HalfW;
  localparam int unsigned DfW = rbsi_pkg::DiffW;
  localparam int unsigned NA  = rbsi_pkg::NumAxes;

  logic                  en;
  logic [Lat-1:0]        vld_q;

  logic signed [CW-1:0]  cen   [0:NA-1];
  logic        [HW-1:0]  half  [0:NA-1];
  logic signed [CW-1:0]  orig  [0:NA-1];
  logic signed [CW-1:0]  dir   [0:NA-1];

  logic signed [DfW-1:0] dlo_q [0:NA-1];
  logic signed [DfW-1:0] dhi_q [0:NA-1];
  logic signed [CW-1:0]  dir_q [0:NA-1];

  rbsi_pkg::quot_t       qlo   [0:NA-1];
  rbsi_pkg::quot_t       qhi   [0:NA-1];

  logic signed [CW-1:0]  lo_q  [0:NA-1];
  logic signed [CW-1:0]  hi_q  [0:NA-1];
  logic        [NA-1:0]  aok_q;

  logic signed [CW-1:0]  enter_d, leave_d, enter_q, leave_q;
  logic                  hit_d, hit_q;

  assign en            = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar a = 0; a < NA; a++) begin : g_axis
    assign cen[a]  = s_axis_tdata[a*CW +: CW];
    assign half[a] = s_axis_tdata[NA*CW + a*HW +: HW];
    assign orig[a] = s_axis_tdata[NA*(CW+HW) + a*CW +: CW];
    assign dir[a]  = s_axis_tdata[NA*(2*CW+HW) + a*CW +: CW];

    always_ff @(posedge clk_i) begin
      if (en) begin
        dlo_q[a] <= DfW'(cen[a]) - $signed({{(DfW-HW){1'b0}}, half[a]}) - DfW'(orig[a]);
        dhi_q[a] <= DfW'(cen[a]) + $signed({{(DfW-HW){1'b0}}, half[a]}) - DfW'(orig[a]);
        dir_q[a] <= dir[a];
      end
    end

    rbsi_div u_div_lo (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (dlo_q[a]),
      .den_i  (dir_q[a]),
      .quot_o (qlo[a])
    );

    rbsi_div u_div_hi (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (dhi_q[a]),
      .den_i  (dir_q[a]),
      .quot_o (qhi[a])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        lo_q[a]  <= (qlo[a].t < qhi[a].t) ? qlo[a].t : qhi[a].t;
        hi_q[a]  <= (qlo[a].t < qhi[a].t) ? qhi[a].t : qlo[a].t;
        aok_q[a] <= qlo[a].ok && qhi[a].ok;
      end
    end
  end

  always_comb begin
    enter_d = lo_q[0];
    leave_d = hi_q[0];
    for (int a = 1; a < NA; a++) begin
      if (lo_q[a] > enter_d) begin
        enter_d = lo_q[a];
      end
      if (hi_q[a] < leave_d) begin
        leave_d = hi_q[a];
      end
    end
    hit_d = (&aok_q) && (enter_d <= leave_d);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= hit_d;
      enter_q <= hit_d ? enter_d : '0;
      leave_q <= hit_d ? leave_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata  = {{(rbsi_pkg::OutDataW-2*CW-1){1'b0}}, leave_q, enter_q, hit_q};

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !hit_q |-> enter_q == '0 && leave_q == '0)
    else $error("miss result carries nonzero parameters");

  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && hit_q |-> enter_q <= leave_q)
    else $error("hit result with enter after exit");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

endmodule
